### sv/cyhh_pkg.sv
// Package for the cylindrical hit histogram core.
// Holds the configuration and command types, register indexes, reset values
// and the arctangent table. No dependencies.
package cyhh_pkg;

    localparam int RADIAL_MAX_DEF = 64;
    localparam int ANGLE_MAX_DEF  = 16;
    localparam int HEIGHT_MAX_DEF = 64;
    localparam int CORDIC_STEPS   = 16;

    localparam logic [2:0] CFG_RADIUS_LIMIT = 3'd0;
    localparam logic [2:0] CFG_TOP_LIMIT    = 3'd1;
    localparam logic [2:0] CFG_BOTTOM_LIMIT = 3'd2;
    localparam logic [2:0] CFG_RADIAL_BINS  = 3'd3;
    localparam logic [2:0] CFG_ANGLE_BINS   = 3'd4;
    localparam logic [2:0] CFG_HEIGHT_BINS  = 3'd5;

    localparam logic [14:0]        RADIUS_RST = 15'd2560;
    localparam logic signed [15:0] TOP_RST    = -16'sd128;
    localparam logic signed [15:0] BOTTOM_RST = -16'sd10816;
    localparam logic [6:0]         RADIAL_RST = 7'd40;
    localparam logic [4:0]         ANGLE_RST  = 5'd10;
    localparam logic [6:0]         HEIGHT_RST = 7'd40;

    typedef struct packed {
        logic [14:0]        radius_limit;
        logic signed [15:0] top_limit;
        logic signed [15:0] bottom_limit;
        logic [6:0]         radial_bins;
        logic [4:0]         angle_bins;
        logic [6:0]         height_bins;
    } t_cfg;

    typedef struct packed {
        logic        in_vol;
        logic [5:0]  bin_radial;
        logic [3:0]  bin_angle;
        logic [5:0]  bin_height;
        logic        use_mem;
        logic        upd;
        logic [15:0] energy;
        logic [15:0] hits;
    } t_cmd;

    function automatic logic [13:0] atan_turn(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/cylindrical_hit_histogram_core.sv
// Cylindrical hit histogram core: configuration registers, front end, queue, store.
// Deposits inside the volume go through the front end's multiply, iteration, divide and
// finish states, using the shared restoring divider; reads and outside deposits skip them.
// The store takes one request at a time.
// After reset the store is cleared, one entry a cycle, RADIAL_MAX*ANGLE_MAX*HEIGHT_MAX
// entries (65536 by default); requests are held off until then.
module cylindrical_hit_histogram_core import cyhh_pkg::*; #(
    parameter int RADIAL_MAX = RADIAL_MAX_DEF,
    parameter int ANGLE_MAX  = ANGLE_MAX_DEF,
    parameter int HEIGHT_MAX = HEIGHT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [15:0]        i_deposit_energy,
    input  logic [15:0]        i_event_hits,
    input  logic               i_last_in_event,
    input  logic [5:0]         i_read_radial,
    input  logic [3:0]         i_read_angle,
    input  logic [5:0]         i_read_height,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_inside_res,
    output logic [5:0]         o_bin_radial,
    output logic [3:0]         o_bin_angle,
    output logic [5:0]         o_bin_height,
    output logic [31:0]        o_event_total,
    output logic [31:0]        o_energy_total,
    output logic [31:0]        o_hit_total
);

    localparam int DEPTH = RADIAL_MAX * ANGLE_MAX * HEIGHT_MAX;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int QW    = $bits(t_cmd) + AW;

    t_cfg          r_cfg;
    logic          f_busy, f_push, q_full, q_valid, q_pop, clearing, acc;
    t_cmd          f_cmd, q_cmd;
    logic [AW-1:0] f_addr, q_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_limit <= RADIUS_RST;
            r_cfg.top_limit <= TOP_RST;
            r_cfg.bottom_limit <= BOTTOM_RST;
            r_cfg.radial_bins <= RADIAL_RST;
            r_cfg.angle_bins <= ANGLE_RST;
            r_cfg.height_bins <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS_LIMIT: r_cfg.radius_limit <= i_cfg_data[14:0];
                CFG_TOP_LIMIT:    r_cfg.top_limit <= $signed(i_cfg_data);
                CFG_BOTTOM_LIMIT: r_cfg.bottom_limit <= $signed(i_cfg_data);
                CFG_RADIAL_BINS:  r_cfg.radial_bins <= i_cfg_data[6:0];
                CFG_ANGLE_BINS:   r_cfg.angle_bins <= i_cfg_data[4:0];
                CFG_HEIGHT_BINS:  r_cfg.height_bins <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_stall = f_busy || clearing;
    assign acc     = i_valid && !o_stall;

    cyhh_front #(
        .RADIAL_MAX(RADIAL_MAX), .ANGLE_MAX(ANGLE_MAX), .HEIGHT_MAX(HEIGHT_MAX)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(acc), .i_cfg(r_cfg),
        .i_mode(i_mode), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_deposit_energy(i_deposit_energy), .i_event_hits(i_event_hits),
        .i_last_in_event(i_last_in_event), .i_read_radial(i_read_radial),
        .i_read_angle(i_read_angle), .i_read_height(i_read_height),
        .i_full(q_full), .o_busy(f_busy), .o_push(f_push), .o_cmd(f_cmd), .o_addr(f_addr)
    );

    cyhh_queue #(.WIDTH(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_push), .i_data({f_cmd, f_addr}),
        .i_pop(q_pop), .o_full(q_full), .o_valid(q_valid), .o_data({q_cmd, q_addr})
    );

    cyhh_back #(
        .RADIAL_MAX(RADIAL_MAX), .ANGLE_MAX(ANGLE_MAX), .HEIGHT_MAX(HEIGHT_MAX)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_cmd(q_cmd),
        .i_addr(q_addr), .o_pop(q_pop), .o_clearing(clearing), .i_stall(i_stall),
        .o_valid(o_valid), .o_inside_res(o_inside_res), .o_bin_radial(o_bin_radial),
        .o_bin_angle(o_bin_angle), .o_bin_height(o_bin_height),
        .o_event_total(o_event_total), .o_energy_total(o_energy_total),
        .o_hit_total(o_hit_total)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full) else $error("push into full queue");

    a_no_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> !clearing) else $error("request taken during store clear");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_event_total == 32'd0 &&
        o_energy_total == 32'd0 && o_hit_total == 32'd0))
        else $error("discarded deposit with non-zero totals");

endmodule

### sv/cyhh_front.sv
// Front end: accepts requests, tests the volume and works out the bins.
// Uses an iterative square root, a CORDIC unit and one shared divider.
// Depends on cyhh_pkg.
module cyhh_front import cyhh_pkg::*; #(
    parameter int RADIAL_MAX = RADIAL_MAX_DEF,
    parameter int ANGLE_MAX  = ANGLE_MAX_DEF,
    parameter int HEIGHT_MAX = HEIGHT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  t_cfg               i_cfg,
    input  logic               i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [15:0]        i_deposit_energy,
    input  logic [15:0]        i_event_hits,
    input  logic               i_last_in_event,
    input  logic [5:0]         i_read_radial,
    input  logic [3:0]         i_read_angle,
    input  logic [5:0]         i_read_height,
    input  logic               i_full,
    output logic               o_busy,
    output logic               o_push,
    output t_cmd               o_cmd,
    output logic [((RADIAL_MAX*ANGLE_MAX*HEIGHT_MAX) > 1 ?
                   $clog2(RADIAL_MAX*ANGLE_MAX*HEIGHT_MAX) : 1)-1:0] o_addr
);

    localparam int DEPTH = RADIAL_MAX * ANGLE_MAX * HEIGHT_MAX;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int NRW   = $clog2(RADIAL_MAX + 1);
    localparam int NAW   = $clog2(ANGLE_MAX + 1);
    localparam int NHW   = $clog2(HEIGHT_MAX + 1);
    localparam int PW    = 32 + 2 * NRW;
    localparam int SQW   = PW / 2;
    localparam int HNW   = 17 + NHW;
    localparam int DW    = HNW > SQW ? HNW : SQW;
    localparam int CW    = $clog2(DW + 1);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL1 = 3'd1;
    localparam logic [2:0] F_MUL2 = 3'd2;
    localparam logic [2:0] F_ITER = 3'd3;
    localparam logic [2:0] F_HB   = 3'd4;
    localparam logic [2:0] F_RDIV = 3'd5;
    localparam logic [2:0] F_FIN  = 3'd6;
    localparam logic [2:0] F_PUSH = 3'd7;

    logic [2:0]         r_state;
    logic [CW-1:0]      r_cnt;
    logic signed [15:0] r_x, r_y, r_z;
    logic [15:0]        r_energy, r_hits;
    logic [NRW-1:0]     r_nr;
    logic [NAW-1:0]     r_na, r_ab;
    logic [NHW-1:0]     r_nh;
    logic [31:0]        r_xx, r_yy;
    logic [2*NRW-1:0]   r_nr2;
    logic [HNW-1:0]     r_hnum;
    logic [16:0]        r_hden;
    logic [PW-1:0]      r_rad;
    logic [SQW+2:0]     r_srem;
    logic [SQW-1:0]     r_root;
    logic signed [25:0] r_cx, r_cy;
    logic signed [17:0] r_cz;
    logic [DW-1:0]      r_dvd, r_hb;
    logic [16:0]        r_rem, r_dvs;
    t_cmd               r_cmd;
    logic [AW-1:0]      r_addr;

    logic signed [16:0] xs, ys, zs, rl, ax, ay, rx, ry;
    logic               in_vol;
    logic [NRW-1:0]     nr_c;
    logic [NAW-1:0]     na_c;
    logic [NHW-1:0]     nh_c;
    logic               rd_ok;
    t_cmd               rd_cmd;
    logic [AW-1:0]      rd_addr;
    logic [SQW+2:0]     s_rem, s_trial;
    logic [17:0]        d_rem;
    logic               d_ge;
    logic [3:0]         c_i;
    logic signed [25:0] c_dx, c_dy;
    logic signed [17:0] c_t;
    logic [15:0]        q, ang;
    logic [16+NAW-1:0]  aprod;
    logic [NAW-1:0]     ab;
    logic [DW-1:0]      rbf, hbf;
    logic [16:0]        dz;

    always_comb begin
        xs = 17'(i_pos_x);
        ys = 17'(i_pos_y);
        zs = 17'(i_pos_z);
        rl = $signed({2'b00, i_cfg.radius_limit});
        in_vol = (xs > -rl) && (xs < rl) && (ys > -rl) && (ys < rl) &&
                 (zs > 17'(i_cfg.bottom_limit)) && (zs < 17'(i_cfg.top_limit));
        if (i_cfg.radial_bins == 7'd0)                nr_c = NRW'(1);
        else if (32'(i_cfg.radial_bins) > RADIAL_MAX) nr_c = NRW'(RADIAL_MAX);
        else                                          nr_c = NRW'(i_cfg.radial_bins);
        if (i_cfg.angle_bins == 5'd0)                 na_c = NAW'(1);
        else if (32'(i_cfg.angle_bins) > ANGLE_MAX)   na_c = NAW'(ANGLE_MAX);
        else                                          na_c = NAW'(i_cfg.angle_bins);
        if (i_cfg.height_bins == 7'd0)                nh_c = NHW'(1);
        else if (32'(i_cfg.height_bins) > HEIGHT_MAX) nh_c = NHW'(HEIGHT_MAX);
        else                                          nh_c = NHW'(i_cfg.height_bins);

        rd_ok = (32'(i_read_radial) < RADIAL_MAX) && (32'(i_read_angle) < ANGLE_MAX) &&
                (32'(i_read_height) < HEIGHT_MAX);
        rd_cmd = '0;
        rd_cmd.in_vol = 1'b1;
        rd_cmd.bin_radial = i_read_radial;
        rd_cmd.bin_angle = i_read_angle;
        rd_cmd.bin_height = i_read_height;
        rd_cmd.use_mem = rd_ok;
        rd_addr = AW'((32'(i_read_height) * ANGLE_MAX + 32'(i_read_angle)) * RADIAL_MAX
                      + 32'(i_read_radial));

        rx = 17'(r_x);
        ry = 17'(r_y);
        ax = r_x < 0 ? -rx : rx;
        ay = r_y < 0 ? -ry : ry;
        dz = 17'(17'(i_cfg.top_limit) - 17'(r_z));

        s_rem = {r_srem[SQW:0], r_rad[PW-1:PW-2]};
        s_trial = (SQW+3)'({r_root, 2'b01});

        d_rem = {r_rem, r_dvd[DW-1]};
        d_ge = d_rem >= {1'b0, r_dvs};

        c_i = r_cnt[3:0];
        c_dx = r_cy >>> c_i;
        c_dy = r_cx >>> c_i;
        c_t = 18'(atan_turn(c_i));

        if (ay == 17'sd0)      q = 16'd0;
        else if (ax == 17'sd0) q = 16'd16384;
        else if (ax == ay)     q = 16'd8192;
        else if (r_cz < 0)     q = 16'd0;
        else if (r_cz > 18'sd16384) q = 16'd16384;
        else                   q = 16'(r_cz);
        if (r_x >= 0 && r_y >= 0) ang = q;
        else if (r_y >= 0)        ang = 16'd32768 - q;
        else if (r_x < 0)         ang = 16'd32768 + q;
        else                      ang = 16'd0 - q;
        aprod = (16+NAW)'(ang) * (16+NAW)'(r_na);
        ab = aprod[16+NAW-1:16];
        if (ab >= r_na) ab = r_na - NAW'(1);

        rbf = (r_dvd == DW'(r_nr)) ? DW'(r_nr) - DW'(1) : r_dvd;
        hbf = (r_hb >= DW'(r_nh)) ? DW'(r_nh) - DW'(1) : r_hb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_acc) begin
                        r_x <= i_pos_x;
                        r_y <= i_pos_y;
                        r_z <= i_pos_z;
                        r_energy <= i_deposit_energy;
                        r_hits <= i_last_in_event ? i_event_hits : 16'd0;
                        r_nr <= nr_c;
                        r_na <= na_c;
                        r_nh <= nh_c;
                        if (i_mode) begin
                            r_cmd <= rd_cmd;
                            r_addr <= rd_addr;
                            r_state <= F_PUSH;
                        end else if (!in_vol) begin
                            r_cmd <= '0;
                            r_addr <= '0;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_MUL1;
                        end
                    end
                end
                F_MUL1: begin
                    r_xx <= 32'(r_x * r_x);
                    r_yy <= 32'(r_y * r_y);
                    r_nr2 <= (2*NRW)'(r_nr) * (2*NRW)'(r_nr);
                    r_hnum <= HNW'(dz) * HNW'(r_nh);
                    r_hden <= 17'(17'(i_cfg.top_limit) - 17'(i_cfg.bottom_limit));
                    r_cx <= 26'({1'b0, ax, 8'd0});
                    r_cy <= 26'({1'b0, ay, 8'd0});
                    r_cz <= '0;
                    r_state <= F_MUL2;
                end
                F_MUL2: begin
                    r_rad <= PW'(r_xx + r_yy) * PW'(r_nr2);
                    r_srem <= '0;
                    r_root <= '0;
                    r_dvd <= DW'(r_hnum);
                    r_rem <= '0;
                    r_dvs <= r_hden;
                    r_cnt <= '0;
                    r_state <= F_ITER;
                end
                F_ITER: begin
                    if (32'(r_cnt) < SQW) begin
                        r_rad <= r_rad << 2;
                        if (s_rem >= s_trial) begin
                            r_srem <= s_rem - s_trial;
                            r_root <= {r_root[SQW-2:0], 1'b1};
                        end else begin
                            r_srem <= s_rem;
                            r_root <= {r_root[SQW-2:0], 1'b0};
                        end
                    end
                    if (32'(r_cnt) < CORDIC_STEPS) begin
                        if (r_cy > 0) begin
                            r_cx <= r_cx + c_dx;
                            r_cy <= r_cy - c_dy;
                            r_cz <= r_cz + c_t;
                        end else begin
                            r_cx <= r_cx - c_dx;
                            r_cy <= r_cy + c_dy;
                            r_cz <= r_cz - c_t;
                        end
                    end
                    r_rem <= d_ge ? 17'(d_rem - {1'b0, r_dvs}) : 17'(d_rem);
                    r_dvd <= {r_dvd[DW-2:0], d_ge};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DW - 1)) r_state <= F_HB;
                end
                F_HB: begin
                    r_hb <= r_dvd;
                    r_ab <= ab;
                    r_dvd <= DW'(r_root);
                    r_rem <= '0;
                    r_dvs <= 17'(i_cfg.radius_limit);
                    r_cnt <= '0;
                    r_state <= F_RDIV;
                end
                F_RDIV: begin
                    r_rem <= d_ge ? 17'(d_rem - {1'b0, r_dvs}) : 17'(d_rem);
                    r_dvd <= {r_dvd[DW-2:0], d_ge};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DW - 1)) r_state <= F_FIN;
                end
                F_FIN: begin
                    if (r_dvd > DW'(r_nr)) begin
                        r_cmd <= '0;
                        r_addr <= '0;
                    end else begin
                        r_cmd.in_vol <= 1'b1;
                        r_cmd.bin_radial <= 6'(rbf);
                        r_cmd.bin_angle <= 4'(r_ab);
                        r_cmd.bin_height <= 6'(hbf);
                        r_cmd.use_mem <= 1'b1;
                        r_cmd.upd <= 1'b1;
                        r_cmd.energy <= r_energy;
                        r_cmd.hits <= r_hits;
                        r_addr <= AW'((32'(hbf) * ANGLE_MAX + 32'(r_ab)) * RADIAL_MAX
                                      + 32'(rbf));
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_busy = r_state != F_IDLE;
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_cmd  = r_cmd;
    assign o_addr = r_addr;

endmodule

### sv/cyhh_queue.sv
// Two-entry queue between the front end and the counter store.
// Generic width; no package dependency.
module cyhh_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

endmodule

### sv/cyhh_back.sv
// Back end: counter store with read-modify-write and the result register.
// Clears the store after reset. Depends on cyhh_pkg.
module cyhh_back import cyhh_pkg::*; #(
    parameter int RADIAL_MAX = RADIAL_MAX_DEF,
    parameter int ANGLE_MAX  = ANGLE_MAX_DEF,
    parameter int HEIGHT_MAX = HEIGHT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    input  logic [((RADIAL_MAX*ANGLE_MAX*HEIGHT_MAX) > 1 ?
                   $clog2(RADIAL_MAX*ANGLE_MAX*HEIGHT_MAX) : 1)-1:0] i_addr,
    output logic        o_pop,
    output logic        o_clearing,
    input  logic        i_stall,
    output logic        o_valid,
    output logic        o_inside_res,
    output logic [5:0]  o_bin_radial,
    output logic [3:0]  o_bin_angle,
    output logic [5:0]  o_bin_height,
    output logic [31:0] o_event_total,
    output logic [31:0] o_energy_total,
    output logic [31:0] o_hit_total
);

    localparam int DEPTH = RADIAL_MAX * ANGLE_MAX * HEIGHT_MAX;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    localparam logic B_IDLE = 1'b0;
    localparam logic B_UPD  = 1'b1;

    logic [95:0]   r_mem [DEPTH];
    logic [95:0]   r_rdata;
    logic          r_state, r_clearing, r_ov;
    logic [AW-1:0] r_clr, r_addr;
    t_cmd          r_cmd;
    logic [31:0]   r_evt, r_eng, r_hit;

    logic          we;
    logic [AW-1:0] waddr;
    logic [95:0]   wdata;
    logic [31:0]   n_evt, n_eng, n_hit;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    always_comb begin
        o_pop = (r_state == B_IDLE) && !r_clearing && i_q_valid && (!r_ov || !i_stall);
        if (!r_cmd.use_mem) begin
            n_evt = '0;
            n_eng = '0;
            n_hit = '0;
        end else if (r_cmd.upd) begin
            n_evt = sat_add(r_rdata[95:64], 32'd1);
            n_eng = sat_add(r_rdata[63:32], 32'(r_cmd.energy));
            n_hit = sat_add(r_rdata[31:0], 32'(r_cmd.hits));
        end else begin
            n_evt = r_rdata[95:64];
            n_eng = r_rdata[63:32];
            n_hit = r_rdata[31:0];
        end
        we = r_clearing || ((r_state == B_UPD) && r_cmd.upd);
        waddr = r_clearing ? r_clr : r_addr;
        wdata = r_clearing ? 96'd0 : {n_evt, n_eng, n_hit};
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_clearing <= 1'b1;
            r_clr <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) r_clearing <= 1'b0;
            end
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_addr <= i_addr;
                        r_state <= B_UPD;
                    end
                end
                B_UPD: begin
                    r_ov <= 1'b1;
                    r_evt <= n_evt;
                    r_eng <= n_eng;
                    r_hit <= n_hit;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_clearing     = r_clearing;
    assign o_valid        = r_ov;
    assign o_inside_res   = r_cmd.in_vol;
    assign o_bin_radial   = r_cmd.bin_radial;
    assign o_bin_angle    = r_cmd.bin_angle;
    assign o_bin_height   = r_cmd.bin_height;
    assign o_event_total  = r_evt;
    assign o_energy_total = r_eng;
    assign o_hit_total    = r_hit;

endmodule
